FILE: src/tvsw_pkg.sv
// ---------------------------------------------------------------------------
// tvsw_pkg
// Shared constants, register indexes and the WSS CRC helper.
// ---------------------------------------------------------------------------
package tvsw_pkg;

  // register indexes
  localparam logic [2:0] REG_WIDESCREEN = 3'd0;
  localparam logic [2:0] REG_STANDARD   = 3'd1;
  localparam logic [2:0] REG_SCALE      = 3'd2;
  localparam logic [2:0] REG_MAX_W      = 3'd3;
  localparam logic [2:0] REG_MAX_H      = 3'd4;
  localparam logic [2:0] REG_X_OFF      = 3'd5;
  localparam logic [2:0] REG_Y_OFF      = 3'd6;
  localparam logic [2:0] REG_DYN_ASP    = 3'd7;

  localparam logic [6:0]  SCALE_RST = 7'd100;
  localparam logic [11:0] MAX_W_RST = 12'd720;
  localparam logic [11:0] MAX_H_RST = 12'd576;
  localparam logic [8:0]  OFF_RST   = 9'h1ff;
  localparam logic [11:0] OUT_MAX   = 12'd4095;
  localparam logic [6:0]  PERCENT   = 7'd100;

  // default offsets per standard
  localparam logic [7:0] PAL_X_DEF  = 8'd4;
  localparam logic [7:0] PAL_Y_DEF  = 8'd4;
  localparam logic [7:0] NTSC_X_DEF = 8'd28;
  localparam logic [7:0] NTSC_Y_DEF = 8'd2;

  // WSS codes
  localparam logic [3:0]  PAL_4_3      = 4'h8;
  localparam logic [3:0]  PAL_16_9     = 4'h7;
  localparam logic [3:0]  PAL_LB_14_9  = 4'h1;
  localparam logic [3:0]  PAL_LB_16_9  = 4'hb;
  localparam logic [13:0] NTSC_4_3     = 14'h0;
  localparam logic [13:0] NTSC_16_9    = 14'h1;
  localparam logic [13:0] NTSC_LB_14_9 = 14'h0;
  localparam logic [13:0] NTSC_LB_16_9 = 14'h2;

  localparam logic [5:0] CRC_POLY   = 6'h30;
  localparam logic [5:0] CRC_PRESET = 6'h3f;

  // reciprocals for the constant divisors: q = (x * rcp) >> shift, exact
  // over the operand ranges used
  localparam int          RCP_SHIFT = 33;
  localparam logic [30:0] RCP_16    = 31'd536870912;
  localparam logic [30:0] RCP_64    = 31'd134217728;
  localparam logic [30:0] RCP_9     = 31'd954437177;
  localparam logic [30:0] RCP_6     = 31'd1431655766;
  localparam int          PCT_SHIFT = 26;
  localparam logic [19:0] RCP_PCT   = 20'd671089;

  // divider defaults
  localparam int DIV_NW = 24;
  localparam int DIV_DW = 12;
  localparam int DIV_SW = 1;

  // IEC 61880 CRC-6, LSB first, over 14 bits
  function automatic logic [5:0] crc6(input logic [13:0] data);
    logic [5:0] c;
    c = CRC_PRESET;
    for (int i = 0; i < 14; i++) begin
      if (c[0] ^ data[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/tvsw_div.sv
// ---------------------------------------------------------------------------
// tvsw_div
// Pipelined restoring divider, one quotient bit per stage, side data carried.
// ---------------------------------------------------------------------------
module tvsw_div #(
  parameter int NW = tvsw_pkg::DIV_NW,
  parameter int DW = tvsw_pkg::DIV_DW,
  parameter int SW = tvsw_pkg::DIV_SW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          vld_o,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_o
);
  import tvsw_pkg::*;

  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];
  logic          vld_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [NW-1:0] num_p;
    logic [NW-1:0] quo_p;
    logic [SW-1:0] side_p;
    logic          vld_p;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign den_p  = den;
      assign num_p  = num;
      assign quo_p  = '0;
      assign side_p = side;
      assign vld_p  = vld;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign den_p  = den_q[k-1];
      assign num_p  = num_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    assign trial = {rem_p, num_p[NW-1]};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
        num_q[k]  <= num_p << 1;
        quo_q[k]  <= {quo_p[NW-2:0], ge};
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign vld_o  = vld_q[NW-1];
  assign quo    = quo_q[NW-1];
  assign side_o = side_q[NW-1];

endmodule

FILE: src/tv_out_scaling_and_wss.sv
// ---------------------------------------------------------------------------
// tv_out_scaling_and_wss
// Picture placement on a PAL/NTSC frame plus widescreen signalling word.
// ---------------------------------------------------------------------------
// From input transfer to result: two 24-stage divider
// pipelines (full height and width fit), a reciprocal multiply for each of
// the constant divisions, and the registers between them.
// Throughput one item per cycle; the whole pipeline holds while a result waits.
// Synchronous reset clears the valid bits and loads the register defaults.
module tv_out_scaling_and_wss (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] source_width,
  input  logic [11:0] source_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] place_x,
  output logic [11:0] place_y,
  output logic [11:0] scaled_width,
  output logic [11:0] scaled_height,
  output logic [19:0] wss_code,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import tvsw_pkg::*;

  typedef struct packed {
    logic [19:0] wss;
    logic        wide;
    logic        hne;
    logic        hz;
    logic [11:0] w;
    logic [11:0] h;
  } sd1_t;

  typedef struct packed {
    logic [19:0] wss;
    logic [11:0] h1;
  } sd2_t;

  typedef struct packed {
    logic [19:0] wss;
    logic        big;
    logic [11:0] w2;
    logic [11:0] h1;
  } sd3_t;

  // configuration
  logic        widescreen_tv, tv_standard, dynamic_aspect;
  logic [6:0]  scale_percent;
  logic [11:0] max_width, max_height;
  logic [8:0]  x_offset, y_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      widescreen_tv  <= 1'b0;
      tv_standard    <= 1'b0;
      scale_percent  <= SCALE_RST;
      max_width      <= MAX_W_RST;
      max_height     <= MAX_H_RST;
      x_offset       <= OFF_RST;
      y_offset       <= OFF_RST;
      dynamic_aspect <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDESCREEN: widescreen_tv  <= cfg_data[0];
        REG_STANDARD:   tv_standard    <= cfg_data[0];
        REG_SCALE:      scale_percent  <= cfg_data[6:0];
        REG_MAX_W:      max_width      <= cfg_data;
        REG_MAX_H:      max_height     <= cfg_data;
        REG_X_OFF:      x_offset       <= cfg_data[8:0];
        REG_Y_OFF:      y_offset       <= cfg_data[8:0];
        REG_DYN_ASP:    dynamic_aspect <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // aspect class and WSS word
  logic [15:0] w9, h16, h14, w3, h4;
  logic        lb16, lb14, narrow, wide0;
  logic [3:0]  pal_w;
  logic [13:0] ntsc_w;
  logic [19:0] wss0;

  assign w9  = 16'(source_width) * 16'd9;
  assign h16 = {source_height, 4'b0};
  assign h14 = 16'(source_height) * 16'd14;
  assign w3  = 16'(source_width) * 16'd3;
  assign h4  = {2'b0, source_height, 2'b0};

  always_comb begin
    lb16   = dynamic_aspect && (w9 >= h16);
    lb14   = dynamic_aspect && (w9 >= h14);
    narrow = dynamic_aspect && (w3 <= h4);
    wide0  = 1'b0;
    if (!widescreen_tv) begin
      if (lb16) begin
        pal_w = PAL_LB_16_9; ntsc_w = NTSC_LB_16_9;
      end else if (lb14) begin
        pal_w = PAL_LB_14_9; ntsc_w = NTSC_LB_14_9;
      end else begin
        pal_w = PAL_4_3; ntsc_w = NTSC_4_3;
      end
    end else if (narrow) begin
      pal_w = PAL_4_3; ntsc_w = NTSC_4_3;
    end else begin
      wide0 = 1'b1;
      pal_w = PAL_16_9; ntsc_w = NTSC_16_9;
    end
    wss0 = tv_standard ? {crc6(ntsc_w), ntsc_w} : 20'(pal_w);
  end

  // stage 1: full-height product
  logic        v1;
  logic [23:0] prod1;
  sd1_t        sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1    <= 24'(source_width) * 24'(max_height);
      sd1.wss  <= wss0;
      sd1.wide <= wide0;
      sd1.hne  <= source_height != max_height;
      sd1.hz   <= source_height == 12'd0;
      sd1.w    <= source_width;
      sd1.h    <= source_height;
    end
  end

  logic        v1o;
  logic [23:0] q1;
  sd1_t        sd1o;

  tvsw_div #(.NW(24), .DW(12), .SW($bits(sd1_t))) u_div_h (
    .clk(clk), .rst(rst), .en(en), .vld(v1), .num(prod1), .den(sd1.h),
    .side(sd1), .vld_o(v1o), .quo(q1), .side_o(sd1o)
  );

  // stage 2: aspect and resolution ratio (reduced fractions), the divisor
  // applied as a reciprocal multiply in the following stage
  logic [23:0] w1;
  logic [11:0] h1;
  logic [5:0]  kmul;
  logic [30:0] krcp;

  always_comb begin
    w1 = sd1o.hne ? (sd1o.hz ? 24'd0 : q1) : 24'(sd1o.w);
    h1 = sd1o.hne ? max_height : sd1o.h;
    case ({tv_standard, sd1o.wide})
      2'b00:   begin kmul = 6'd15; krcp = RCP_16; end
      2'b01:   begin kmul = 6'd45; krcp = RCP_64; end
      2'b10:   begin kmul = 6'd10; krcp = RCP_9;  end
      2'b11:   begin kmul = 6'd5;  krcp = RCP_6;  end
      default: begin kmul = 6'd15; krcp = RCP_16; end
    endcase
  end

  logic        v2;
  logic [29:0] num2;
  logic [30:0] rcp2;
  sd2_t        sd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1o;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2    <= 30'(w1) * 30'(kmul);
      rcp2    <= krcp;
      sd2.wss <= sd1o.wss;
      sd2.h1  <= h1;
    end
  end

  logic        v2p;
  logic [60:0] prod2;
  sd2_t        sd2p;
  logic [29:0] q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2p <= 1'b0;
    end else if (en) begin
      v2p <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= 61'(num2) * 61'(rcp2);
      sd2p  <= sd2;
    end
  end

  assign q2 = 30'(prod2 >> RCP_SHIFT);

  // stage 3: shrink to max width
  logic        v3;
  logic [23:0] num3;
  logic [24:0] den3;
  sd3_t        sd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num3    <= 24'(sd2p.h1) * 24'(max_width);
      den3    <= q2[24:0];
      sd3.wss <= sd2p.wss;
      sd3.big <= q2 > 30'(max_width);
      sd3.w2  <= q2[11:0];
      sd3.h1  <= sd2p.h1;
    end
  end

  logic        v3o;
  logic [23:0] q3;
  sd3_t        sd3o;

  tvsw_div #(.NW(24), .DW(25), .SW($bits(sd3_t))) u_div_fit (
    .clk(clk), .rst(rst), .en(en), .vld(v3), .num(num3), .den(den3),
    .side(sd3), .vld_o(v3o), .quo(q3), .side_o(sd3o)
  );

  // stage 4: percentage scaling, divide by 100 as a reciprocal multiply
  logic [11:0] w3s, h3s;
  assign w3s = sd3o.big ? max_width : sd3o.w2;
  assign h3s = sd3o.big ? q3[11:0] : sd3o.h1;

  logic        v4;
  logic [18:0] pw, ph;
  logic [19:0] wss4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3o;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw   <= 19'(w3s) * 19'(scale_percent);
      ph   <= 19'(h3s) * 19'(scale_percent);
      wss4 <= sd3o.wss;
    end
  end

  logic        v5;
  logic [38:0] prw, prh;
  logic [19:0] wss5;
  logic [12:0] qw, qh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prw  <= 39'(pw) * 39'(RCP_PCT);
      prh  <= 39'(ph) * 39'(RCP_PCT);
      wss5 <= wss4;
    end
  end

  assign qw = 13'(prw >> PCT_SHIFT);
  assign qh = 13'(prh >> PCT_SHIFT);

  // stage 5: saturation and centring
  logic [11:0] ws, hs, xo, yo, px, py;
  logic [13:0] xsum, ysum;
  logic        xfit, yfit;

  always_comb begin
    ws = (qw > 13'(OUT_MAX)) ? OUT_MAX : qw[11:0];
    hs = (qh > 13'(OUT_MAX)) ? OUT_MAX : qh[11:0];
    xo = x_offset[8] ? 12'(tv_standard ? NTSC_X_DEF : PAL_X_DEF) : {4'b0, x_offset[7:0]};
    yo = y_offset[8] ? 12'(tv_standard ? NTSC_Y_DEF : PAL_Y_DEF) : {4'b0, y_offset[7:0]};
    // fits when size + offset stays inside the frame
    xfit = (13'(ws) + 13'(xo)) <= 13'(max_width);
    yfit = (13'(hs) + 13'(yo)) <= 13'(max_height);
    xsum = 14'(max_width) + 14'(xo) - 14'(ws);
    ysum = 14'(max_height) + 14'(yo) - 14'(hs);
    if (xfit) begin
      px = xsum[12:1];
    end else begin
      px = (max_width >= ws) ? max_width - ws : 12'd0;
    end
    if (yfit) begin
      py = ysum[12:1];
    end else begin
      py = (max_height >= hs) ? max_height - hs : 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      place_x       <= px;
      place_y       <= py;
      scaled_width  <= ws;
      scaled_height <= hs;
      wss_code      <= wss5;
    end
  end

endmodule

FILE: sim/tb_tv_out_scaling_and_wss.sv
// ---------------------------------------------------------------------------
// tb_tv_out_scaling_and_wss
// Self-checking bench for picture placement and WSS generation. A local
// predictor computes each expected placement; a monitor compares every result
// transfer in order. Configurations span PAL/NTSC, 4:3/16:9, dynamic aspect,
// offsets, scaling and frame size extremes, with random stalls on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tv_out_scaling_and_wss;
  import tvsw_pkg::*;

  localparam int LATENCY     = 54;
  localparam int CYCLE_CAP   = 400000;
  localparam int HOLD_CYCLES = 300;

  // aspect classes
  localparam int ASP_4_3     = 0;
  localparam int ASP_16_9    = 1;
  localparam int ASP_LB_14_9 = 2;
  localparam int ASP_LB_16_9 = 3;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic [11:0] sw;
    logic [11:0] sh;
    logic [19:0] wss;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] source_width = '0;
  logic [11:0] source_height = 12'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] place_x, place_y, scaled_width, scaled_height;
  logic [19:0] wss_code;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  // shadow of the block's registers
  logic        sh_wide, sh_ntsc, sh_dyn;
  logic [6:0]  sh_scale;
  logic [11:0] sh_mw, sh_mh;
  logic [8:0]  sh_xoff, sh_yoff;

  placement_t placement_q[$];
  int  errors = 0;
  int  cycles = 0;
  int  results_seen = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_off = 0;
  bit  rx_random = 1'b1;

  tv_out_scaling_and_wss i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [5:0] wss_crc(input logic [13:0] d);
    logic [5:0] c;
    c = 6'h3f;
    for (int i = 0; i < 14; i++) begin
      if (c[0] ^ d[i]) c = (c >> 1) ^ 6'h30;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic placement_t predict_placement(input logic [11:0] sw_in,
                                                   input logic [11:0] sh_in);
    longint w, h, mw, mh, xa, ya, ah, xo, yo, px, py;
    logic   wide;
    int     asp;
    logic [19:0] wss;
    placement_t r;
    w = sw_in; h = sh_in; mw = sh_mw; mh = sh_mh; wide = sh_wide;
    if (!wide) begin
      if (sh_dyn && 9 * w >= 16 * h) asp = ASP_LB_16_9;
      else if (sh_dyn && 9 * w >= 14 * h) asp = ASP_LB_14_9;
      else asp = ASP_4_3;
    end else if (sh_dyn && 3 * w <= 4 * h) begin
      wide = 1'b0; asp = ASP_4_3;
    end else asp = ASP_16_9;
    if (sh_ntsc) begin
      case (asp)
        ASP_16_9:    wss = NTSC_16_9;
        ASP_LB_14_9: wss = NTSC_LB_14_9;
        ASP_LB_16_9: wss = NTSC_LB_16_9;
        default:     wss = NTSC_4_3;
      endcase
      wss[19:14] = wss_crc(wss[13:0]);
    end else begin
      case (asp)
        ASP_16_9:    wss = PAL_16_9;
        ASP_LB_14_9: wss = PAL_LB_14_9;
        ASP_LB_16_9: wss = PAL_LB_16_9;
        default:     wss = PAL_4_3;
      endcase
    end
    ah = sh_ntsc ? 486 : 576;
    xa = wide ? 16 : 4;
    ya = wide ? 9 : 3;
    if (h != mh) begin
      w = (h != 0) ? (w * mh) / h : 0;
      h = mh;
    end
    w = (w * ya * 720) / (xa * ah);
    if (w > mw) begin
      h = (h * mw) / w;
      w = mw;
    end
    w = (w * sh_scale) / 100;
    h = (h * sh_scale) / 100;
    if (w > 4095) w = 4095;
    if (h > 4095) h = 4095;
    xo = sh_xoff[8] ? (sh_ntsc ? 28 : 4) : sh_xoff;
    yo = sh_yoff[8] ? (sh_ntsc ? 2 : 4) : sh_yoff;
    px = (w > mw - xo) ? mw - w : (mw + xo - w) / 2;
    py = (h > mh - yo) ? mh - h : (mh + yo - h) / 2;
    if (px < 0) px = 0;
    if (py < 0) py = 0;
    if (px > 4095) px = 4095;
    if (py > 4095) py = 4095;
    r.px = px[11:0]; r.py = py[11:0]; r.sw = w[11:0]; r.sh = h[11:0]; r.wss = wss;
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDESCREEN: sh_wide = val[0];
      REG_STANDARD:   sh_ntsc = val[0];
      REG_SCALE:      sh_scale = val[6:0];
      REG_MAX_W:      sh_mw = val;
      REG_MAX_H:      sh_mh = val;
      REG_X_OFF:      sh_xoff = val[8:0];
      REG_Y_OFF:      sh_yoff = val[8:0];
      REG_DYN_ASP:    sh_dyn = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic wide, input logic ntsc, input logic [6:0] sc,
                            input logic [11:0] mw, input logic [11:0] mh,
                            input logic [8:0] xo, input logic [8:0] yo,
                            input logic dyn);
    write_reg(REG_WIDESCREEN, 12'(wide));
    write_reg(REG_STANDARD, 12'(ntsc));
    write_reg(REG_SCALE, 12'(sc));
    write_reg(REG_MAX_W, mw);
    write_reg(REG_MAX_H, mh);
    write_reg(REG_X_OFF, 12'(xo));
    write_reg(REG_Y_OFF, 12'(yo));
    write_reg(REG_DYN_ASP, 12'(dyn));
  endtask

  // valid stays high after the transfer until the next call or drain
  task automatic send_size(input logic [11:0] w, input logic [11:0] h, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 10) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1; source_width <= w; source_height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    placement_q.push_back(predict_placement(w, h));
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // result side: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (rx_random) out_ready <= ($urandom_range(0, 10) < 7);
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      placement_t e;
      results_seen++;
      if (placement_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = placement_q.pop_front();
        if (place_x !== e.px) begin
          $error("place_x exp %0d got %0d", e.px, place_x); errors++;
        end
        if (place_y !== e.py) begin
          $error("place_y exp %0d got %0d", e.py, place_y); errors++;
        end
        if (scaled_width !== e.sw) begin
          $error("scaled_width exp %0d got %0d", e.sw, scaled_width); errors++;
        end
        if (scaled_height !== e.sh) begin
          $error("scaled_height exp %0d got %0d", e.sh, scaled_height); errors++;
        end
        if (wss_code !== e.wss) begin
          $error("wss_code exp %h got %h", e.wss, wss_code); errors++;
        end
      end
    end
  end

  task automatic test_reset_defaults;
    sh_wide = 0; sh_ntsc = 0; sh_scale = SCALE_RST; sh_mw = MAX_W_RST;
    sh_mh = MAX_H_RST; sh_xoff = OFF_RST; sh_yoff = OFF_RST; sh_dyn = 0;
    send_size(12'd720, 12'd576, 1'b0);
    send_size(12'd1920, 12'd1080, 1'b0);
    send_size(12'd0, 12'd1, 1'b0);
    send_size(12'd4095, 12'd4095, 1'b0);
    drain();
  endtask

  task automatic test_aspect_classes;
    for (int c = 0; c < 8; c++) begin
      set_config(c[0], c[1], 7'd100, 12'd720, c[1] ? 12'd486 : 12'd576,
                 9'h1ff, 9'h1ff, c[2]);
      send_size(12'd1600, 12'd900, 1'b1);   // 16:9 letterbox
      send_size(12'd1400, 12'd900, 1'b1);   // 14:9
      send_size(12'd640, 12'd480, 1'b1);    // 4:3
      drain();
    end
  endtask

  task automatic test_extremes;
    // zero source height, saturating scale, zero frame, max frame, offsets
    set_config(1'b0, 1'b0, 7'd127, 12'd4095, 12'd4095, 9'd255, 9'd0, 1'b1);
    send_size(12'd100, 12'd0, 1'b0);
    send_size(12'd4095, 12'd1, 1'b0);
    send_size(12'd1, 12'd4095, 1'b0);
    drain();
    set_config(1'b1, 1'b1, 7'd0, 12'd0, 12'd0, 9'd0, 9'd255, 1'b0);
    send_size(12'd720, 12'd0, 1'b0);
    send_size(12'd720, 12'd480, 1'b0);
    drain();
    set_config(1'b0, 1'b1, 7'd50, 12'd1, 12'd1, 9'h100, 9'd1, 1'b1);
    send_size(12'd4095, 12'd4095, 1'b0);
    send_size(12'd2730, 12'd4095, 1'b0);
    drain();
  endtask

  task automatic random_config;
    logic [11:0] mw, mh;
    mw = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095)) : 12'($urandom_range(600, 800));
    mh = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095)) : 12'($urandom_range(400, 600));
    set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               ($urandom_range(0, 4) == 0) ? 7'($urandom_range(101, 127))
                                           : 7'($urandom_range(0, 100)),
               mw, mh,
               ($urandom_range(0, 2) == 0) ? 9'h1ff : 9'($urandom),
               ($urandom_range(0, 2) == 0) ? 9'h1ff : 9'($urandom),
               1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_sizes;
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      rx_random = (ph % 4 != 3);
      for (int i = 0; i < 35; i++)
        send_size(12'($urandom), ($urandom_range(0, 20) == 0) ? 12'd0 : 12'($urandom),
                  (ph % 4 != 2));
      drain();
    end
  endtask

  task automatic test_backpressure;
    random_config();
    hold_req++;
    for (int i = 0; i < 150; i++) send_size(12'($urandom), 12'($urandom), 1'b0);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_aspect_classes();
    test_extremes();
    test_random_sizes();
    test_backpressure();
    $display("covered %0d results over PAL/NTSC, all aspect classes, offsets,", results_seen);
    $display("scale and frame extremes, random stalls and a long output hold-off");
    if (errors == 0 && placement_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: tv_out_scaling_and_wss.f
src/tvsw_pkg.sv
src/tvsw_div.sv
src/tv_out_scaling_and_wss.sv
sim/tb_tv_out_scaling_and_wss.sv
